// ===== rtl/core/decimal_weighted_name_hash_top_defines.svh =====
// assertion macros shared by the name hash rtl
`ifndef DECIMAL_WEIGHTED_NAME_HASH_TOP_DEFINES_SVH
`define DECIMAL_WEIGHTED_NAME_HASH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, held off while reset is high
`define DWNH_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dwnh assertion failed");
// checked property, also checked during reset
`define DWNH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dwnh assertion failed");
`else
`define DWNH_ASSERT(label, clk, rst, prop)
`define DWNH_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/dwnh_pkg.sv =====
// shared types, constants and tables of the name hash
`default_nettype none

package dwnh_pkg;

  localparam int unsigned DIGIT_BASE      = 48;
  localparam int unsigned RADIX           = 10;
  localparam int unsigned PAD_START       = 40;
  localparam int unsigned PAD_END         = 256;
  localparam int unsigned FINAL_SHIFT     = 7;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned DIGIT_W         = 9;
  localparam int unsigned WEIGHT_W        = 32;
  localparam int unsigned PROD_W          = DIGIT_W + WEIGHT_W;
  localparam int unsigned HASH_W          = 64;
  localparam int unsigned TAIL_W          = 15;
  localparam int unsigned TABLE_DEPTH     = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef logic [WEIGHT_W-1:0] weight_table_t [TABLE_DEPTH];

  // 10^k modulo 2^32, built at elaboration
  function automatic weight_table_t build_weight_table();
    weight_table_t       tbl;
    logic [WEIGHT_W-1:0] w;
    w = WEIGHT_W'(1);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      tbl[k] = w;
      w      = w * WEIGHT_W'(RADIX);
    end
    return tbl;
  endfunction

  localparam weight_table_t WEIGHT_TABLE = build_weight_table();

  // sum of the integers from max(len,40) to 255
  function automatic logic [TAIL_W-1:0] tail_sum(input logic [BYTE_W-1:0] len);
    logic [BYTE_W:0]   m;
    logic [BYTE_W:0]   cnt;
    logic [TAIL_W+1:0] prod;
    m    = (len > BYTE_W'(PAD_START)) ? {1'b0, len} : (BYTE_W+1)'(PAD_START);
    cnt  = (BYTE_W+1)'(PAD_END) - m;
    prod = ((TAIL_W+2)'(m) + (TAIL_W+2)'(PAD_END - 1)) * (TAIL_W+2)'(cnt);
    return prod[TAIL_W:1];
  endfunction

  // one classified byte, as it travels from front to back
  typedef struct packed {
    logic signed [DIGIT_W-1:0]  digit;
    logic        [WEIGHT_W-1:0] weight;
    logic                       first;
    logic                       trunc;
    logic                       last;
    logic        [TAIL_W-1:0]   tail;
  } dwnh_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/dwnh_front.sv =====
// front end: accepts name bytes, tracks position and classifies each byte
`default_nettype none

`include "decimal_weighted_name_hash_top_defines.svh"

module dwnh_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dwnh_pkg::BYTE_W-1:0] name_byte,
  input  wire logic [dwnh_pkg::BYTE_W-1:0] name_length,
  input  wire logic                        full,
  output logic                             push,
  output dwnh_pkg::dwnh_item_t             push_item
);
  import dwnh_pkg::*;

  logic [BYTE_W-1:0] pos;
  logic [BYTE_W-1:0] latched_length;

  logic              is_first;
  logic              is_last;
  logic              accept;
  logic [BYTE_W-1:0] len_in;
  logic [BYTE_W-1:0] len_eff;
  logic [BYTE_W-1:0] weight_idx;

  assign accept   = in_valid && !full;
  assign in_stall = full;
  assign push     = accept;

  always_comb begin
    is_first   = (pos == '0);
    // a zero length behaves as a one-byte name
    len_in     = (name_length == '0) ? BYTE_W'(1) : name_length;
    len_eff    = is_first ? len_in : latched_length;
    is_last    = (pos == len_eff - BYTE_W'(1));
    weight_idx = len_eff - BYTE_W'(1) - pos;

    push_item.digit  = $signed({1'b0, name_byte} - DIGIT_W'(DIGIT_BASE));
    push_item.weight = WEIGHT_TABLE[weight_idx];
    push_item.first  = is_first;
    // leading byte of a longer name wraps its product at 32 bits
    push_item.trunc  = is_first && !is_last;
    push_item.last   = is_last;
    push_item.tail   = tail_sum(len_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      latched_length <= '0;
    end else if (accept) begin
      if (is_first) begin
        latched_length <= len_in;
      end
      pos <= is_last ? '0 : pos + BYTE_W'(1);
    end
  end

  `DWNH_ASSERT(a_pos_in_name, clk, rst, (pos != '0) |-> (pos < latched_length))
  `DWNH_ASSERT(a_pos_wraps_on_last, clk, rst,
    (accept && is_last) |=> (pos == '0))
  `DWNH_ASSERT_ALWAYS(a_no_push_when_full, clk, full |-> !push)

endmodule

`default_nettype wire

// ===== rtl/core/dwnh_queue.sv =====
// short queue of classified bytes between front and back
`default_nettype none

`include "decimal_weighted_name_hash_top_defines.svh"

module dwnh_queue #(
  parameter int unsigned DEPTH = dwnh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire dwnh_pkg::dwnh_item_t push_item,
  output logic                      full,
  output logic                      q_valid,
  input  wire logic                 pop,
  output dwnh_pkg::dwnh_item_t      pop_item
);
  import dwnh_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dwnh_item_t        entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `DWNH_ASSERT(a_count_bounded, clk, rst, count <= CNT_W'(DEPTH))
  `DWNH_ASSERT(a_pop_needs_entry, clk, rst, pop |-> (count != '0))
  `DWNH_ASSERT(a_count_grows, clk, rst,
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))

endmodule

`default_nettype wire

// ===== rtl/core/dwnh_back.sv =====
// back end: weight multiply, running sum and result register
`default_nettype none

`include "decimal_weighted_name_hash_top_defines.svh"

module dwnh_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire dwnh_pkg::dwnh_item_t        q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dwnh_pkg::HASH_W-1:0]      hash_value
);
  import dwnh_pkg::*;

  // multiply stage
  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod;
  logic                     m_first;
  logic                     m_trunc;
  logic                     m_last;
  logic [TAIL_W-1:0]        m_tail;

  logic [HASH_W-1:0]        acc;
  logic [HASH_W-1:0]        term;
  logic [HASH_W-1:0]        acc_sum;
  logic [HASH_W-1:0]        total;

  logic                     out_free;
  logic                     m_consume;
  logic                     m_ready;

  assign out_free  = !out_valid || !out_stall;
  // only the last byte of a name needs room in the result register
  assign m_consume = m_valid && (!m_last || out_free);
  assign m_ready   = !m_valid || m_consume;
  assign q_pop     = q_valid && m_ready;

  always_comb begin
    term    = m_trunc ? {{(HASH_W-WEIGHT_W){1'b0}}, m_prod[WEIGHT_W-1:0]}
                      : {{(HASH_W-PROD_W){m_prod[PROD_W-1]}}, m_prod};
    acc_sum = (m_first ? '0 : acc) + term;
    total   = acc_sum + {{(HASH_W-TAIL_W){1'b0}}, m_tail};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (m_consume && m_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (m_consume) begin
        acc <= m_last ? '0 : acc_sum;
      end
      if (m_ready) begin
        m_valid <= q_pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_prod  <= $signed(q_item.digit) * $signed({1'b0, q_item.weight});
      m_first <= q_item.first;
      m_trunc <= q_item.trunc;
      m_last  <= q_item.last;
      m_tail  <= q_item.tail;
    end
    if (m_consume && m_last) begin
      hash_value <= total << FINAL_SHIFT;
    end
  end

  `DWNH_ASSERT(a_last_gives_result, clk, rst, (m_consume && m_last) |=> out_valid)
  `DWNH_ASSERT(a_hash_low_zero, clk, rst,
    out_valid |-> (hash_value[FINAL_SHIFT-1:0] == '0))
  `DWNH_ASSERT(a_pop_only_when_room, clk, rst, q_pop |-> m_ready)

endmodule

`default_nettype wire

// ===== rtl/core/decimal_weighted_name_hash_top.sv =====
// Decimal positional name hash. A name streams in one byte per transfer, with
// its length (1..255, zero acts as one) taken from the first byte; one 64-bit
// hash leaves after the last byte. The block takes one byte every cycle while
// the queue has room: the front classifies each byte and looks up its weight
// in a constant table, a QUEUE_DEPTH-entry queue decouples it from the back,
// which registers its 9x32 product, then the running sum and result; a hash
// is valid once its last byte has passed the queue and these registers. Input
// stall rises only when the queue is full, which happens while a finished hash
// waits on output stall and further names pile up behind it.
`default_nettype none

module decimal_weighted_name_hash_top #(
  parameter int unsigned QUEUE_DEPTH = dwnh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dwnh_pkg::BYTE_W-1:0] name_byte,
  input  wire logic [dwnh_pkg::BYTE_W-1:0] name_length,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dwnh_pkg::HASH_W-1:0]      hash_value
);
  import dwnh_pkg::*;

  logic       full;
  logic       push;
  dwnh_item_t push_item;
  logic       q_valid;
  logic       q_pop;
  dwnh_item_t q_item;

  dwnh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .name_byte   (name_byte),
    .name_length (name_length),
    .full        (full),
    .push        (push),
    .push_item   (push_item)
  );

  dwnh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  dwnh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire
